[design/svsl_pkg.sv]
// Package for the servo angle slew limiter: shared types, constants and helpers.
`default_nettype none

package svsl_pkg;

  // Field widths
  localparam int unsigned PULSE_W = 12;
  localparam int unsigned STEP_W  = 10;
  localparam int unsigned DEG_W   = 8;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned ADDR_W  = 5;
  localparam int unsigned DATA_W  = 32;

  // Conversion constants
  localparam logic [PULSE_W-1:0] PULSE_OFFSET = 12'd544;
  localparam logic [DEG_W-1:0]   MAX_DEG      = 8'd180;

  // floor(deg*31/3) as one product: 31*43691, shift 17 (exact for deg*31 < 98304)
  localparam logic [20:0] A2P_MULT  = 21'd1354421;
  localparam int unsigned A2P_SHIFT = 17;
  // floor(x*3/31) as one product: 3*16913, shift 19 (exact for 3x < 34952)
  localparam logic [15:0] P2A_MULT  = 16'd50739;
  localparam int unsigned P2A_SHIFT = 19;

  // Register reset values
  localparam logic [PULSE_W-1:0] RST_MIN_PULSE   = 12'd544;
  localparam logic [PULSE_W-1:0] RST_MAX_PULSE   = 12'd2400;
  localparam logic [PULSE_W-1:0] RST_START_PULSE = 12'd1472;
  localparam logic [STEP_W-1:0]  RST_STEP_SIZE   = 10'd0;

  // Register indexes (paddr[4:2])
  localparam logic [2:0] REG_MIN_PULSE   = 3'd0;
  localparam logic [2:0] REG_MAX_PULSE   = 3'd1;
  localparam logic [2:0] REG_START_PULSE = 3'd2;
  localparam logic [2:0] REG_INVERTED    = 3'd3;
  localparam logic [2:0] REG_STEP_SIZE   = 3'd4;

  typedef enum logic [CMD_W-1:0] {
    CMD_SET_TARGET = 2'd0,
    CMD_TICK       = 2'd1,
    CMD_HOME       = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [PULSE_W-1:0] min_pulse;
    logic [PULSE_W-1:0] max_pulse;
    logic [PULSE_W-1:0] start_pulse;
    logic               inverted;
    logic [STEP_W-1:0]  step_size;
  } cfg_t;

  // When the limits cross, a value below the low limit gives the low limit and any other value gives the high limit.
  function automatic logic [PULSE_W-1:0] clamp_pulse(
    input logic [PULSE_W-1:0] p,
    input logic [PULSE_W-1:0] lo,
    input logic [PULSE_W-1:0] hi
  );
    logic [PULSE_W-1:0] r;
    if (p < lo) begin
      r = lo;
    end else if (p > hi) begin
      r = hi;
    end else begin
      r = p;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[design/servo_angle_slew_limiter.sv]
// Top level of the servo angle slew limiter: handshake pipeline and result register.
`default_nettype none

// Servo joint controller with a slew-limited pulse width. Each input beat
// carries a command (set target, tick, home) and an angle; each one yields
// exactly one result beat with the pulse width and the position, target,
// min and max angles after that command. The block takes one beat per
// cycle while the output accepts results; a beat passes through the
// input register, the state register (updated as the beat leaves the
// input register) and the result register, and back pressure on the
// output stalls the pipe stage by stage without losing a beat. Set
// target saturates the angle to 180, mirrors it when inverted,
// maps it to deg*31/3 + 544 and clamps to the min/max pulse registers; tick
// moves the position by at most step_size and lands on the target exactly;
// home loads both pulses from start_pulse unclamped. Configuration sits on
// an APB port (register i at byte 4*i, pready tied high) and must only be
// written while no beat is in flight. No clearing pass after reset.
module servo_angle_slew_limiter (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // configuration port
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [svsl_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [svsl_pkg::DATA_W-1:0]  pwdata,
  output logic      [svsl_pkg::DATA_W-1:0]  prdata,
  output logic                              pready,
  // input channel
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [svsl_pkg::CMD_W-1:0]   command_i,
  input  wire logic [svsl_pkg::DEG_W-1:0]   angle_deg_i,
  // result channel
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic      [svsl_pkg::PULSE_W-1:0] pulse_width_o,
  output logic      [svsl_pkg::DEG_W-1:0]   position_deg_o,
  output logic      [svsl_pkg::DEG_W-1:0]   target_deg_o,
  output logic      [svsl_pkg::DEG_W-1:0]   min_deg_o,
  output logic      [svsl_pkg::DEG_W-1:0]   max_deg_o
);

  svsl_pkg::cfg_t cfg;

  svsl_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Pipe control. Stage 1 holds the input beat, stage 2 is the state
  // register itself (its valid bit marks a beat whose effect is in the
  // state but not yet reported), stage 3 is the result register.
  logic                         s1_valid_q, s1_valid_d;
  logic [svsl_pkg::CMD_W-1:0]   s1_cmd_q;
  logic [svsl_pkg::DEG_W-1:0]   s1_angle_q;
  logic                         s2_valid_q, s2_valid_d;
  logic                         out_valid_q, out_valid_d;
  logic                         out_free, s2_move, s2_free, s1_move, in_take;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s2_move    = s2_valid_q && out_free;
  assign s2_free    = !s2_valid_q || s2_move;
  assign s1_move    = s1_valid_q && s2_free;
  assign in_ready_o = !s1_valid_q || s1_move;
  assign in_take    = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d  = in_take ? 1'b1 : (s1_move ? 1'b0 : s1_valid_q);
    s2_valid_d  = s1_move ? 1'b1 : (s2_move ? 1'b0 : s2_valid_q);
    out_valid_d = s2_move ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      s2_valid_q  <= s2_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_cmd_q   <= command_i;
      s1_angle_q <= angle_deg_i;
    end
  end

  // state update happens as the beat leaves stage 1
  logic [svsl_pkg::PULSE_W-1:0] position, target;

  svsl_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (s1_move),
    .cmd_i      (s1_cmd_q),
    .angle_i    (s1_angle_q),
    .cfg_i      (cfg),
    .position_o (position),
    .target_o   (target)
  );

  // back conversion to degrees, one converter per reported angle
  logic [svsl_pkg::DEG_W-1:0] pos_deg, tgt_deg, min_deg, max_deg;

  svsl_pulse2deg u_p2d_pos (
    .pulse_i     (position),
    .min_pulse_i (cfg.min_pulse),
    .max_pulse_i (cfg.max_pulse),
    .inverted_i  (cfg.inverted),
    .deg_o       (pos_deg)
  );

  svsl_pulse2deg u_p2d_tgt (
    .pulse_i     (target),
    .min_pulse_i (cfg.min_pulse),
    .max_pulse_i (cfg.max_pulse),
    .inverted_i  (cfg.inverted),
    .deg_o       (tgt_deg)
  );

  svsl_pulse2deg u_p2d_min (
    .pulse_i     (cfg.min_pulse),
    .min_pulse_i (cfg.min_pulse),
    .max_pulse_i (cfg.max_pulse),
    .inverted_i  (cfg.inverted),
    .deg_o       (min_deg)
  );

  svsl_pulse2deg u_p2d_max (
    .pulse_i     (cfg.max_pulse),
    .min_pulse_i (cfg.min_pulse),
    .max_pulse_i (cfg.max_pulse),
    .inverted_i  (cfg.inverted),
    .deg_o       (max_deg)
  );

  // result register
  logic [svsl_pkg::PULSE_W-1:0] pulse_q;
  logic [svsl_pkg::DEG_W-1:0]   pos_deg_q, tgt_deg_q, min_deg_q, max_deg_q;

  always_ff @(posedge clk_i) begin
    if (s2_move) begin
      pulse_q   <= position;
      pos_deg_q <= pos_deg;
      tgt_deg_q <= tgt_deg;
      min_deg_q <= min_deg;
      max_deg_q <= max_deg;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pulse_width_o  = pulse_q;
  assign position_deg_o = pos_deg_q;
  assign target_deg_o   = tgt_deg_q;
  assign min_deg_o      = min_deg_q;
  assign max_deg_o      = max_deg_q;

endmodule

`default_nettype wire

[design/svsl_cfg_regs.sv]
// APB register file for the servo slew limiter configuration.
`default_nettype none

module svsl_cfg_regs (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [svsl_pkg::ADDR_W-1:0] paddr,
  input  wire logic [svsl_pkg::DATA_W-1:0] pwdata,
  output logic      [svsl_pkg::DATA_W-1:0] prdata,
  output logic                             pready,
  output svsl_pkg::cfg_t                   cfg_o
);

  svsl_pkg::cfg_t cfg_q, cfg_d;
  logic [2:0]     reg_idx;
  logic           wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        svsl_pkg::REG_MIN_PULSE:   cfg_d.min_pulse   = pwdata[svsl_pkg::PULSE_W-1:0];
        svsl_pkg::REG_MAX_PULSE:   cfg_d.max_pulse   = pwdata[svsl_pkg::PULSE_W-1:0];
        svsl_pkg::REG_START_PULSE: cfg_d.start_pulse = pwdata[svsl_pkg::PULSE_W-1:0];
        svsl_pkg::REG_INVERTED:    cfg_d.inverted    = pwdata[0];
        svsl_pkg::REG_STEP_SIZE:   cfg_d.step_size   = pwdata[svsl_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_pulse   <= svsl_pkg::RST_MIN_PULSE;
      cfg_q.max_pulse   <= svsl_pkg::RST_MAX_PULSE;
      cfg_q.start_pulse <= svsl_pkg::RST_START_PULSE;
      cfg_q.inverted    <= 1'b0;
      cfg_q.step_size   <= svsl_pkg::RST_STEP_SIZE;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (reg_idx)
      svsl_pkg::REG_MIN_PULSE:   prdata = {20'd0, cfg_q.min_pulse};
      svsl_pkg::REG_MAX_PULSE:   prdata = {20'd0, cfg_q.max_pulse};
      svsl_pkg::REG_START_PULSE: prdata = {20'd0, cfg_q.start_pulse};
      svsl_pkg::REG_INVERTED:    prdata = {31'd0, cfg_q.inverted};
      svsl_pkg::REG_STEP_SIZE:   prdata = {22'd0, cfg_q.step_size};
      default:                   prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[design/svsl_pulse2deg.sv]
// Pulse width to angle converter with limit clamp, saturation and mirroring.
`default_nettype none

module svsl_pulse2deg (
  input  wire logic [svsl_pkg::PULSE_W-1:0] pulse_i,
  input  wire logic [svsl_pkg::PULSE_W-1:0] min_pulse_i,
  input  wire logic [svsl_pkg::PULSE_W-1:0] max_pulse_i,
  input  wire logic                         inverted_i,
  output logic      [svsl_pkg::DEG_W-1:0]   deg_o
);

  logic [svsl_pkg::PULSE_W-1:0] p_clamp;
  logic [svsl_pkg::PULSE_W-1:0] p_ofs;
  logic [27:0]                  prod;
  logic [8:0]                   d_raw;
  logic [svsl_pkg::DEG_W-1:0]   d_sat;

  assign p_clamp = svsl_pkg::clamp_pulse(pulse_i, min_pulse_i, max_pulse_i);
  // below the offset reads as 0 degrees before mirroring
  assign p_ofs   = (p_clamp < svsl_pkg::PULSE_OFFSET) ? '0
                                                      : p_clamp - svsl_pkg::PULSE_OFFSET;
  assign prod    = 28'(p_ofs) * 28'(svsl_pkg::P2A_MULT);
  assign d_raw   = prod[svsl_pkg::P2A_SHIFT +: 9];
  assign d_sat   = (d_raw > 9'(svsl_pkg::MAX_DEG)) ? svsl_pkg::MAX_DEG : d_raw[7:0];
  assign deg_o   = inverted_i ? (svsl_pkg::MAX_DEG - d_sat) : d_sat;

endmodule

`default_nettype wire

[design/svsl_core.sv]
// Position and target state with set-target conversion, slew tick and home.
`default_nettype none

module svsl_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         adv_i,
  input  wire logic [svsl_pkg::CMD_W-1:0]   cmd_i,
  input  wire logic [svsl_pkg::DEG_W-1:0]   angle_i,
  input  wire svsl_pkg::cfg_t               cfg_i,
  output logic      [svsl_pkg::PULSE_W-1:0] position_o,
  output logic      [svsl_pkg::PULSE_W-1:0] target_o
);

  logic [svsl_pkg::PULSE_W-1:0] position_q, position_d;
  logic [svsl_pkg::PULSE_W-1:0] target_q, target_d;

  // set target: angle -> pulse
  logic [svsl_pkg::DEG_W-1:0]   deg_sat, deg_m;
  logic [28:0]                  a2p_prod;
  logic [svsl_pkg::PULSE_W-1:0] a2p_raw, a2p_pulse;

  assign deg_sat   = (angle_i > svsl_pkg::MAX_DEG) ? svsl_pkg::MAX_DEG : angle_i;
  assign deg_m     = cfg_i.inverted ? (svsl_pkg::MAX_DEG - deg_sat) : deg_sat;
  assign a2p_prod  = 29'(deg_m) * 29'(svsl_pkg::A2P_MULT);
  assign a2p_raw   = a2p_prod[svsl_pkg::A2P_SHIFT +: svsl_pkg::PULSE_W]
                     + svsl_pkg::PULSE_OFFSET;
  assign a2p_pulse = svsl_pkg::clamp_pulse(a2p_raw, cfg_i.min_pulse, cfg_i.max_pulse);

  // tick: step toward target, land on it when close
  logic [svsl_pkg::PULSE_W-1:0] step_ext, diff_up, diff_dn, tick_pos;

  assign step_ext = {2'd0, cfg_i.step_size};
  assign diff_up  = target_q - position_q;
  assign diff_dn  = position_q - target_q;

  always_comb begin
    if (position_q < target_q) begin
      tick_pos = (diff_up <= step_ext) ? target_q : position_q + step_ext;
    end else if (position_q > target_q) begin
      tick_pos = (diff_dn <= step_ext) ? target_q : position_q - step_ext;
    end else begin
      tick_pos = position_q;
    end
  end

  always_comb begin
    position_d = position_q;
    target_d   = target_q;
    if (adv_i) begin
      case (cmd_i)
        svsl_pkg::CMD_SET_TARGET: target_d = a2p_pulse;
        svsl_pkg::CMD_TICK:       position_d = tick_pos;
        svsl_pkg::CMD_HOME: begin
          position_d = cfg_i.start_pulse;
          target_d   = cfg_i.start_pulse;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      position_q <= svsl_pkg::RST_START_PULSE;
      target_q   <= svsl_pkg::RST_START_PULSE;
    end else begin
      position_q <= position_d;
      target_q   <= target_d;
    end
  end

  assign position_o = position_q;
  assign target_o   = target_q;

`ifndef NO_ASSERTIONS
  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv_i |=> $stable(position_q) && $stable(target_q))
    else $error("state changed without an advancing beat");

  a_tick_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && cmd_i == svsl_pkg::CMD_TICK && position_q <= target_q
    |=> position_q >= $past(position_q) && position_q <= target_q)
    else $error("upward tick overshot the target");

  a_tick_dn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && cmd_i == svsl_pkg::CMD_TICK && position_q >= target_q
    |=> position_q <= $past(position_q) && position_q >= target_q)
    else $error("downward tick overshot the target");

  a_home: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && cmd_i == svsl_pkg::CMD_HOME
    |=> position_q == target_q && position_q == $past(cfg_i.start_pulse))
    else $error("home did not load the start pulse");
`endif

endmodule

`default_nettype wire
